@@ hw/rtl/delta_speech_synth_sequencer_core_assert.svh @@
// ----------------------------------------------------------------------------
// delta_speech_synth_sequencer_core_assert.svh
// Assertion macros used by the sequencer core RTL.
// ----------------------------------------------------------------------------
`ifndef DELTA_SPEECH_SYNTH_SEQUENCER_CORE_ASSERT_SVH
`define DELTA_SPEECH_SYNTH_SEQUENCER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DSS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dss assertion failed: same-cycle implication");

// next-cycle implication, checked out of reset
`define DSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dss assertion failed: next-cycle implication");

`endif

@@ hw/rtl/dss_pkg.sv @@
// ----------------------------------------------------------------------------
// dss_pkg
// Types and constants of the delta speech synth sequencer.
// ----------------------------------------------------------------------------
package dss_pkg;

  typedef struct packed {
    logic       start_pin;
    logic [5:0] word_number;
    logic [7:0] rom_data;
  } in_t;

  typedef struct packed {
    logic [3:0]  sample_level;
    logic [11:0] rom_addr;
    logic        busy_res;
  } out_t;

  localparam logic [3:0] LEVEL_MID = 4'd7;
  localparam logic [3:0] LEVEL_MAX = 4'd15;

  // increment by [first][second] delta
  localparam logic [1:0] INC_TBL [4][4] = '{
    '{2'd3, 2'd3, 2'd1, 2'd1},
    '{2'd1, 2'd1, 2'd0, 2'd0},
    '{2'd0, 2'd0, 2'd1, 2'd1},
    '{2'd1, 2'd1, 2'd3, 2'd3}
  };

endpackage

@@ hw/rtl/dss_seq.sv @@
// ----------------------------------------------------------------------------
// dss_seq
// Sequencer state and next-state logic; advances one step per accepted word.
// ----------------------------------------------------------------------------
module dss_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step_en,
  input  dss_pkg::in_t  in_word,
  output dss_pkg::out_t res
);

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_WORDWAIT = 3'd1,
    ST_CWAR_HI  = 3'd2,
    ST_CWAR_LO  = 3'd3,
    ST_DAR_HI   = 3'd4,
    ST_CTRL     = 3'd5,
    ST_PLAY     = 3'd6,
    ST_DELAY    = 3'd7
  } state_t;

  state_t      state_r, state_nxt;
  logic [8:0]  dhigh_r, dhigh_nxt;
  logic [4:0]  dlow_r, dlow_nxt;
  logic [11:0] cwa_r, cwa_nxt;
  logic        stop_r, stop_nxt;
  logic        voiced_r, voiced_nxt;
  logic        silence_r, silence_nxt;
  logic [6:0]  len_r, len_nxt;
  logic [1:0]  rrel_r, rrel_nxt;
  logic [1:0]  pdelta_r, pdelta_nxt;
  logic [3:0]  level_r, level_nxt;
  logic [11:0] maddr_r, maddr_nxt;
  logic        busy_r, busy_nxt;

  logic        start;
  logic [7:0]  rom;
  logic [1:0]  qtr;
  logic        mirror, vmir, pp_start, dcarry, rep, lcarry;
  logic [1:0]  dadr, delta, old, inc;
  logic        add;
  logic [3:0]  lv;
  logic [4:0]  lsum;
  logic [3:0]  lsat;
  logic [4:0]  a;
  logic [5:0]  dlow_p4;

  always_comb begin
    start       = in_word.start_pin;
    rom         = in_word.rom_data;
    state_nxt   = state_r;
    dhigh_nxt   = dhigh_r;
    dlow_nxt    = dlow_r;
    cwa_nxt     = cwa_r;
    stop_nxt    = stop_r;
    voiced_nxt  = voiced_r;
    silence_nxt = silence_r;
    len_nxt     = len_r;
    rrel_nxt    = rrel_r;
    pdelta_nxt  = pdelta_r;
    level_nxt   = dss_pkg::LEVEL_MID;
    maddr_nxt   = maddr_r;
    busy_nxt    = busy_r;

    qtr      = len_r[1:0];
    mirror   = qtr[0];
    vmir     = voiced_r && mirror;
    pp_start = (dlow_r == 5'd0);
    dcarry   = (dlow_r == 5'h1f);
    rep      = dcarry && (len_r[3:0] == 4'hf);
    lcarry   = rep && (len_r == 7'h7f);
    dadr     = dlow_r[1:0] ^ {2{vmir}};
    case (dadr)
      2'd0:    delta = rom[7:6];
      2'd1:    delta = rom[5:4];
      2'd2:    delta = rom[3:2];
      default: delta = rom[1:0];
    endcase
    old = (qtr == 2'd0 && pp_start) ? 2'd2 : pdelta_r;
    if (!vmir) begin
      inc = dss_pkg::INC_TBL[delta][old];
      add = delta[1];
    end else begin
      inc = dss_pkg::INC_TBL[old][delta];
      add = !old[1];
    end
    if (vmir && pp_start) begin
      inc = 2'd0;
    end
    lv = (qtr == 2'd0 && pp_start) ? dss_pkg::LEVEL_MID : level_r;
    if (!add) begin
      lv = lv ^ dss_pkg::LEVEL_MAX;
    end
    lsum = {1'b0, lv} + {3'b000, inc};
    lsat = lsum[4] ? dss_pkg::LEVEL_MAX : lsum[3:0];
    if (!add) begin
      lsat = lsat ^ dss_pkg::LEVEL_MAX;
    end
    a       = 5'd0;
    dlow_p4 = {1'b0, dlow_r} + 6'd4;

    case (state_r)
      ST_IDLE: begin
        busy_nxt = 1'b0;
        if (start) begin
          state_nxt = ST_WORDWAIT;
        end
      end
      ST_WORDWAIT: begin
        dhigh_nxt = {5'd0, in_word.word_number[5:2]};
        dlow_nxt  = {in_word.word_number[1:0], 3'b000};
        maddr_nxt = {5'd0, in_word.word_number[5:2], in_word.word_number[1:0], 1'b0};
        busy_nxt  = 1'b1;
        state_nxt = start ? ST_WORDWAIT : ST_CWAR_HI;
      end
      ST_CWAR_HI: begin
        cwa_nxt   = {rom, 4'd0};
        dlow_nxt  = dlow_p4[5] ? 5'd0 : dlow_p4[4:0];
        maddr_nxt = {dhigh_r, dlow_nxt[4:2]};
        state_nxt = start ? ST_WORDWAIT : ST_CWAR_LO;
      end
      ST_CWAR_LO: begin
        cwa_nxt   = {cwa_r[11:4], cwa_r[3:0] | rom[7:4]};
        maddr_nxt = cwa_nxt;
        state_nxt = start ? ST_WORDWAIT : ST_DAR_HI;
      end
      ST_DAR_HI: begin
        dhigh_nxt = {rom, 1'b0};
        dlow_nxt  = 5'd0;
        cwa_nxt   = cwa_r + 12'd1;
        maddr_nxt = cwa_nxt;
        state_nxt = start ? ST_WORDWAIT : ST_CTRL;
      end
      ST_CTRL: begin
        stop_nxt    = rom[7];
        voiced_nxt  = rom[6];
        silence_nxt = rom[5];
        rrel_nxt    = rom[1:0];
        len_nxt     = {rom[4:0], 2'b00};
        dlow_nxt    = 5'd0;
        cwa_nxt     = cwa_r + 12'd1;
        maddr_nxt   = {dhigh_r, 3'b000};
        state_nxt   = start ? ST_WORDWAIT : ST_PLAY;
      end
      ST_PLAY: begin
        pdelta_nxt = delta;
        if (silence_r || (voiced_r && qtr[1])) begin
          level_nxt = dss_pkg::LEVEL_MID;
        end else begin
          level_nxt = lsat;
        end
        dlow_nxt = dlow_r + 5'd1;
        if (dcarry) begin
          len_nxt = len_r + 7'd1;
        end
        if (voiced_r && rep) begin
          len_nxt   = {len_nxt[6:4], rrel_r, 2'b00};
          dhigh_nxt = dhigh_r + 9'd1;
        end
        if (!voiced_r && dcarry) begin
          dhigh_nxt = dhigh_r + 9'd1;
        end
        a         = dlow_nxt ^ {5{voiced_r && len_nxt[0]}};
        maddr_nxt = {dhigh_nxt, a[4:2]};
        if (start) begin
          state_nxt = ST_WORDWAIT;
        end else if (stop_r && lcarry) begin
          state_nxt = ST_DELAY;
        end else if (lcarry) begin
          state_nxt = ST_DAR_HI;
          maddr_nxt = cwa_r;
        end else begin
          state_nxt = ST_PLAY;
        end
      end
      default: begin
        state_nxt = start ? ST_WORDWAIT : ST_IDLE;
      end
    endcase
  end

  assign res.sample_level = level_nxt;
  assign res.rom_addr     = maddr_nxt;
  assign res.busy_res     = busy_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      dhigh_r   <= '0;
      dlow_r    <= '0;
      cwa_r     <= '0;
      stop_r    <= 1'b0;
      voiced_r  <= 1'b0;
      silence_r <= 1'b0;
      len_r     <= '0;
      rrel_r    <= '0;
      pdelta_r  <= '0;
      level_r   <= dss_pkg::LEVEL_MID;
      maddr_r   <= '0;
      busy_r    <= 1'b0;
    end else if (step_en) begin
      state_r   <= state_nxt;
      dhigh_r   <= dhigh_nxt;
      dlow_r    <= dlow_nxt;
      cwa_r     <= cwa_nxt;
      stop_r    <= stop_nxt;
      voiced_r  <= voiced_nxt;
      silence_r <= silence_nxt;
      len_r     <= len_nxt;
      rrel_r    <= rrel_nxt;
      pdelta_r  <= pdelta_nxt;
      level_r   <= level_nxt;
      maddr_r   <= maddr_nxt;
      busy_r    <= busy_nxt;
    end
  end

endmodule

@@ hw/rtl/delta_speech_synth_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// delta_speech_synth_sequencer_core
// Two-bit delta speech synth sequencer with registered result word.
// ----------------------------------------------------------------------------
// Each accepted input word is one clock period of the sequencer: it steps the
// state machine once and yields exactly one result word (level, next memory
// address, busy). A word is taken every cycle unless in_stall is high; the step
// logic sits between the sequencer state registers and the output register,
// and the output register frees itself in the same cycle its word is taken, so
// input stalls only while a result is held by a stalled receiver. The result
// is valid in the cycle after input acceptance.
`include "delta_speech_synth_sequencer_core_assert.svh"

module delta_speech_synth_sequencer_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  dss_pkg::in_t  in_word,
  output logic          out_valid,
  input  logic          out_stall,
  output dss_pkg::out_t out_word
);

  logic          out_valid_r, out_valid_nxt;
  dss_pkg::out_t out_word_r;
  dss_pkg::out_t step_res;
  logic          accept;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  dss_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (accept),
    .in_word (in_word),
    .res     (step_res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_word_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // not busy means the level sits at mid-scale
  `DSS_ASSERT_SAME(a_idle_mid, clk, rst_n, out_valid_r && !out_word_r.busy_res, out_word_r.sample_level == dss_pkg::LEVEL_MID)
  `DSS_ASSERT_NEXT(a_acc_valid, clk, rst_n, accept, out_valid_r)
  `DSS_ASSERT_SAME(a_stall_held, clk, rst_n, in_stall, out_valid_r)

endmodule
